FILE: rtl/core/gcld_pkg.sv
// Package: shared constants and types for the G-code line decoder.
package gcld_pkg;
    localparam int FRAC_DIGITS_DEF = 3;
    localparam int AXIS_COUNT_DEF  = 9;
    localparam logic [30:0] DWELL_RESET = 31'd5000000;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT, PH_INT, PH_FRAC, PH_SKIP, PH_DWELL
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN, ST_EMIT
    } t_state;

    localparam logic [3:0] KW_N      = 4'd0;
    localparam logic [3:0] KW_G      = 4'd1;
    localparam logic [3:0] KW_M      = 4'd2;
    localparam logic [3:0] KW_SCALAR = 4'd3;
    localparam logic [3:0] KW_DWELL  = 4'd4;
    localparam logic [3:0] KW_RADIUS = 4'd5;
    localparam logic [3:0] KW_ANGLE  = 4'd6;
    localparam logic [3:0] KW_AXIS   = 4'd7;

    localparam logic [4:0] KIND_MOTION = 5'd0;
    localparam logic [4:0] KIND_PLANE  = 5'd1;
    localparam logic [4:0] KIND_REL    = 5'd2;
    localparam logic [4:0] KIND_STOP   = 5'd3;
    localparam logic [4:0] KIND_SCALAR = 5'd4;
    localparam logic [4:0] KIND_AXIS   = 5'd8;
    localparam logic [4:0] KIND_ERROR  = 5'd17;

    localparam logic [3:0] ERR_G = 4'd1;
    localparam logic [3:0] ERR_M = 4'd2;

    localparam logic [32:0] MAG_CAP = 33'h0_8000_0000;

    // axis letters, X in the top byte
    localparam logic [71:0] AXIS_LETTERS = "XYZUVWIJK";

    // error number for a word without a number
    function automatic logic [3:0] word_error(input logic [3:0] k);
        logic [3:0] r;
        unique case (k)
            4'd0: r = 4'd0;  4'd1: r = 4'd1;  4'd2: r = 4'd2;  4'd3: r = 4'd3;
            4'd4: r = 4'd0;  4'd5: r = 4'd7;  4'd6: r = 4'd8;
            4'd7, 4'd8, 4'd9: r = 4'd4;
            4'd10, 4'd11, 4'd12: r = 4'd5;
            default: r = 4'd6;
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return is_digit(c) || c == "+" || c == "-" || c == "." || c == "E" || c == "e";
    endfunction

    // 10**n for small n
    function automatic logic [31:0] pow10(input int n);
        logic [31:0] r;
        r = 32'd1;
        for (int i = 0; i < 3; i++) if (i < n) r = r * 32'd10;
        return r;
    endfunction
endpackage

FILE: rtl/core/gcode_line_decoder.sv
// Top level: G-code line decoder, byte in, block items out.
// Output: a line end enters the emit state, which loads block items into the output register.
// Throughput: one byte per cycle while o_stall is low; a byte that closes a word is held and
//   handled again. A line end stalls input while its 8+AXIS_COUNT items go out (mode items
//   one per cycle while i_stall is low, memory items one at a time) or its single error item.
// Reset (synchronous, i_rst_n low): modal state cleared, dwell default 5000000, and all
//   4+AXIS_COUNT words of the value memory swept to zero with input stalled.
module gcode_line_decoder #(
    parameter int FRAC_DIGITS = gcld_pkg::FRAC_DIGITS_DEF,
    parameter int AXIS_COUNT  = gcld_pkg::AXIS_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_ch,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_dwell_default,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_item_kind,
    output logic signed [31:0] o_item_value,
    output logic               o_item_present,
    output logic               o_last_item
);
    // memory map: 0..3 scalars (feed, dwell, radius, angle), 4.. axes
    localparam int DEPTH = 4 + AXIS_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NOUT  = 8 + AXIS_COUNT;
    localparam int XW    = $clog2(AXIS_COUNT);

    logic [30:0] r_dwell_def;
    gcld_pkg::t_phase r_phase, n_phase;
    gcld_pkg::t_state r_state, n_state;
    logic [3:0]  r_kind, n_kind;
    logic        r_neg, n_neg;
    logic [31:0] r_mag, n_mag;
    logic [1:0]  r_fd, n_fd;
    logic [7:0]  r_code, n_code;
    logic [2:0]  r_motion, n_motion;
    logic        r_mgiven, n_mgiven;
    logic [1:0]  r_stop, n_stop;
    logic [1:0]  r_plane, n_plane;
    logic        r_rel, n_rel;
    logic [AXIS_COUNT-1:0] r_apres, n_apres;
    logic [3:0]  r_errn, n_errn;
    logic        r_errl, n_errl;
    logic        r_empty, n_empty;
    logic        r_clr;
    logic [AW-1:0] r_clr_idx;
    logic [4:0]  r_cnt, n_cnt;     // emit index
    logic        r_pend;           // byte held for re-handling
    logic [7:0]  r_hold;
    logic        n_pend;

    // output register
    logic        r_ov;
    logic [4:0]  r_okind;
    logic [31:0] r_oval;
    logic        r_opres, r_olast;
    logic        n_ov_load;
    logic [4:0]  n_okind;
    logic [31:0] n_oval;
    logic        n_opres, n_olast;
    logic        r_rd_pend;        // memory read outstanding for emit
    logic [4:0]  r_rd_kind;
    logic        r_rd_pres, r_rd_last;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    gcld_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [7:0] c;
    logic       take, busy_out;
    assign busy_out = r_ov && i_stall;
    assign c = r_pend ? r_hold : i_ch;
    // new bytes accepted only in run state, after the clear sweep, with no pending re-handle, read or output stall
    assign o_stall = r_clr || r_pend || (r_state != gcld_pkg::ST_RUN) || r_rd_pend || busy_out;
    assign take    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    logic        act;
    logic        code_word;
    logic [7:0]  up;
    logic [35:0] m_int;
    logic [32:0] m_frac;
    logic [11:0] code_nx;
    logic [31:0] num_val;
    logic [3:0]  dig;

    assign act       = take || r_pend;
    assign code_word = r_kind <= gcld_pkg::KW_M;
    assign up        = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    assign dig       = 4'(c - "0");
    // wide enough that a saturated magnitude times ten cannot wrap
    assign m_int  = {4'b0, r_mag} * 36'd10 + 36'(dig) * 36'(gcld_pkg::pow10(FRAC_DIGITS));
    assign m_frac = {1'b0, r_mag} + 33'(dig) * 33'(gcld_pkg::pow10(FRAC_DIGITS - 1 - int'(r_fd)));
    assign code_nx = {4'b0, r_code} * 12'd10 + 12'(dig);
    assign num_val = r_neg ? (32'd0 - r_mag) : (r_mag[31] ? 32'h7FFF_FFFF : r_mag);

    always_comb begin
        n_phase = r_phase; n_state = r_state; n_kind = r_kind; n_neg = r_neg;
        n_mag = r_mag; n_fd = r_fd; n_code = r_code; n_motion = r_motion;
        n_mgiven = r_mgiven; n_stop = r_stop; n_plane = r_plane; n_rel = r_rel;
        n_apres = r_apres; n_errn = r_errn; n_errl = r_errl; n_empty = r_empty;
        n_cnt = r_cnt; n_pend = 1'b0;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        n_ov_load = 1'b0; n_okind = '0; n_oval = '0; n_opres = 1'b1; n_olast = 1'b0;
        if (r_clr) begin
            we = 1'b1; waddr = r_clr_idx;
        end else if (r_state == gcld_pkg::ST_EMIT) begin
            // header items straight from registers, memory items through a read
            if (!busy_out && !r_rd_pend) begin
                if (r_errl) begin
                    n_ov_load = 1'b1; n_okind = gcld_pkg::KIND_ERROR;
                    n_oval = 32'(r_errn); n_olast = 1'b1;
                    n_state = gcld_pkg::ST_RUN;
                end else if (r_cnt < 5'd4) begin
                    n_ov_load = 1'b1; n_okind = r_cnt;
                    unique case (r_cnt[1:0])
                        2'd0: n_oval = 32'(r_motion);
                        2'd1: n_oval = 32'(r_plane);
                        2'd2: n_oval = 32'(r_rel);
                        default: n_oval = 32'(r_stop);
                    endcase
                    n_cnt = r_cnt + 5'd1;
                end else begin
                    raddr = AW'(r_cnt - 5'd4);
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == 5'(NOUT - 1)) n_state = gcld_pkg::ST_RUN;
                end
            end
            if (n_state == gcld_pkg::ST_RUN) begin
                n_mgiven = 1'b0; n_apres = '0; n_stop = 2'd0; n_empty = 1'b1;
            end
        end else if (act) begin
            if (take && i_ch != 8'd10 && i_ch != 8'd0) n_empty = 1'b0;
            unique case (r_phase)
                gcld_pkg::PH_IDLE: begin
                    if (c == 8'd10 || (c == 8'd0 && !(r_empty && !(take && 1'b0)))) begin
                        n_state = gcld_pkg::ST_EMIT; n_cnt = '0;
                    end else if (c != 8'd0) begin
                        n_neg = 1'b0; n_mag = '0; n_fd = '0; n_code = '0;
                        n_phase = gcld_pkg::PH_WAIT;
                        priority case (up)
                            "N": n_kind = gcld_pkg::KW_N;
                            "G": n_kind = gcld_pkg::KW_G;
                            "M": n_kind = gcld_pkg::KW_M;
                            "F": n_kind = gcld_pkg::KW_SCALAR;
                            "R": n_kind = gcld_pkg::KW_RADIUS;
                            "A": n_kind = gcld_pkg::KW_ANGLE;
                            default: begin
                                n_phase = gcld_pkg::PH_IDLE;
                                n_neg = r_neg; n_mag = r_mag; n_fd = r_fd; n_code = r_code;
                                for (int i = 0; i < AXIS_COUNT; i++) begin
                                    if (up == gcld_pkg::AXIS_LETTERS[8*(8-i) +: 8]) begin
                                        n_kind = gcld_pkg::KW_AXIS + 4'(i);
                                        n_apres[i] = 1'b1;
                                        n_neg = 1'b0; n_mag = '0; n_fd = '0; n_code = '0;
                                        n_phase = gcld_pkg::PH_WAIT;
                                    end
                                end
                            end
                        endcase
                    end
                end
                gcld_pkg::PH_WAIT: begin
                    if (c == " ") begin
                    end else if (code_word ? gcld_pkg::is_digit(c) : gcld_pkg::is_num(c)) begin
                        n_phase = gcld_pkg::PH_INT;
                        if (code_word) n_code = 8'(dig);
                        else if (c == "+") begin end
                        else if (c == "-") n_neg = 1'b1;
                        else if (gcld_pkg::is_digit(c))
                            n_mag = m_int > {3'b0, gcld_pkg::MAG_CAP} ? 32'h8000_0000
                                                                       : m_int[31:0];
                        else if (c == ".") n_phase = gcld_pkg::PH_FRAC;
                        else n_phase = gcld_pkg::PH_SKIP;
                    end else begin
                        n_errn = gcld_pkg::word_error(r_kind); n_errl = 1'b1;
                        n_phase = gcld_pkg::PH_IDLE; n_pend = 1'b1;
                    end
                end
                gcld_pkg::PH_DWELL: begin
                    if (c == " ") begin
                    end else if (gcld_pkg::is_digit(c)) begin
                        n_phase = gcld_pkg::PH_INT;
                        n_mag = m_int > {3'b0, gcld_pkg::MAG_CAP} ? 32'h8000_0000 : m_int[31:0];
                    end else begin
                        we = 1'b1; waddr = AW'(1); wdata = {1'b0, r_dwell_def};
                        n_phase = gcld_pkg::PH_IDLE; n_pend = 1'b1;
                    end
                end
                default: begin
                    // INT, FRAC, SKIP
                    logic fin;
                    fin = 1'b0;
                    if (r_phase == gcld_pkg::PH_INT && code_word) begin
                        if (gcld_pkg::is_digit(c)) begin
                            if (code_nx > 12'd255) n_code = 8'd255;
                            else n_code = code_nx[7:0];
                        end else fin = 1'b1;
                    end else if (r_phase == gcld_pkg::PH_INT) begin
                        if (gcld_pkg::is_digit(c))
                            n_mag = m_int > {3'b0, gcld_pkg::MAG_CAP} ? 32'h8000_0000
                                                                       : m_int[31:0];
                        else if (c == ".") n_phase = gcld_pkg::PH_FRAC;
                        else if (gcld_pkg::is_num(c)) n_phase = gcld_pkg::PH_SKIP;
                        else fin = 1'b1;
                    end else if (r_phase == gcld_pkg::PH_FRAC) begin
                        if (gcld_pkg::is_digit(c)) begin
                            if (int'(r_fd) < FRAC_DIGITS) begin
                                n_mag = m_frac > gcld_pkg::MAG_CAP ? 32'h8000_0000 : m_frac[31:0];
                                n_fd = r_fd + 2'd1;
                            end
                        end else if (gcld_pkg::is_num(c)) n_phase = gcld_pkg::PH_SKIP;
                        else fin = 1'b1;
                    end else begin
                        if (!gcld_pkg::is_num(c)) fin = 1'b1;
                    end
                    if (fin) begin
                        n_pend = 1'b1; n_phase = gcld_pkg::PH_IDLE;
                        if (r_kind == gcld_pkg::KW_G) begin
                            if (r_code <= 8'd4) begin
                                if (r_mgiven) begin
                                    n_errn = gcld_pkg::ERR_G; n_errl = 1'b1;
                                end else begin
                                    n_motion = 3'(r_code) + 3'd1; n_mgiven = 1'b1;
                                    if (r_code == 8'd4) begin
                                        n_kind = gcld_pkg::KW_DWELL; n_neg = 1'b0;
                                        n_mag = '0; n_fd = '0; n_code = '0;
                                        n_phase = gcld_pkg::PH_DWELL;
                                    end
                                end
                            end else if (r_code >= 8'd17 && r_code <= 8'd19)
                                n_plane = 2'(r_code - 8'd17);
                            else if (r_code == 8'd90) n_rel = 1'b0;
                            else if (r_code == 8'd91) n_rel = 1'b1;
                        end else if (r_kind == gcld_pkg::KW_M) begin
                            if (r_code == 8'd0) n_stop = 2'd1;
                            else if (r_code == 8'd1) n_stop = 2'd2;
                            else if (r_code == 8'd30) n_stop = 2'd3;
                            else begin n_errn = gcld_pkg::ERR_M; n_errl = 1'b1; end
                        end else if (r_kind >= gcld_pkg::KW_SCALAR) begin
                            we = 1'b1; waddr = AW'(r_kind - gcld_pkg::KW_SCALAR);
                            wdata = num_val;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_def <= gcld_pkg::DWELL_RESET;
            r_phase <= gcld_pkg::PH_IDLE; r_state <= gcld_pkg::ST_RUN;
            r_kind <= '0; r_neg <= 1'b0; r_mag <= '0; r_fd <= '0; r_code <= '0;
            r_motion <= '0; r_mgiven <= 1'b0; r_stop <= '0; r_plane <= '0; r_rel <= 1'b0;
            r_apres <= '0; r_errn <= '0; r_errl <= 1'b0; r_empty <= 1'b1;
            r_clr <= 1'b1; r_clr_idx <= '0; r_cnt <= '0; r_pend <= 1'b0;
            r_ov <= 1'b0; r_rd_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) r_dwell_def <= i_dwell_default;
            r_phase <= n_phase; r_state <= n_state; r_kind <= n_kind; r_neg <= n_neg;
            r_mag <= n_mag; r_fd <= n_fd; r_code <= n_code; r_motion <= n_motion;
            r_mgiven <= n_mgiven; r_stop <= n_stop; r_plane <= n_plane; r_rel <= n_rel;
            r_apres <= n_apres; r_errn <= n_errn; r_errl <= n_errl; r_empty <= n_empty;
            r_cnt <= n_cnt; r_pend <= n_pend;
            if (r_clr) begin
                if (r_clr_idx == AW'(DEPTH - 1)) r_clr <= 1'b0;
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            // memory item in flight
            r_rd_pend <= (r_state == gcld_pkg::ST_EMIT) && !r_errl && !busy_out
                         && !r_rd_pend && r_cnt >= 5'd4;
            // a load finds the output register empty or draining; a read return finds it empty
            r_ov <= n_ov_load || r_rd_pend || (r_ov && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_hold <= i_ch;
        r_rd_kind <= gcld_pkg::KIND_SCALAR + r_cnt - 5'd4;
        r_rd_pres <= (r_cnt < 5'd8 || r_cnt >= 5'(NOUT)) ? 1'b1
                                                          : r_apres[XW'(r_cnt - 5'd8)];
        r_rd_last <= r_cnt == 5'(NOUT - 1);
        if (n_ov_load) begin
            r_okind <= n_okind; r_oval <= n_oval; r_opres <= n_opres; r_olast <= n_olast;
        end else if (r_rd_pend) begin
            r_okind <= r_rd_kind; r_oval <= rdata; r_opres <= r_rd_pres;
            r_olast <= r_rd_last;
        end
    end

    assign o_valid        = r_ov;
    assign o_item_kind    = r_okind;
    assign o_item_value   = r_oval;
    assign o_item_present = r_opres;
    assign o_last_item    = r_olast;

    a_no_take_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gcld_pkg::ST_EMIT) |-> !take) else $error("byte taken during emit");
    a_no_take_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !take) else $error("byte taken during clear");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_errl) |-> r_errl) else $error("error latch dropped");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_okind == gcld_pkg::KIND_ERROR) |-> r_olast) else $error("error not last");
endmodule

FILE: rtl/core/gcld_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module gcld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: test/gcode_line_decoder_test.sv
// Testbench for the G-code line decoder: directed and random text in, block items checked.
module gcode_line_decoder_test;

    // one item of an emitted block
    typedef struct {
        logic [4:0]  kind;
        logic [31:0] value;
        logic        present;
        logic        last;
    } t_block_item;

    // Tracks the parser state byte by byte and queues the block items each
    // accepted byte should produce.
    class t_block_tracker;
        logic [30:0] dwell_dflt;
        logic [3:0]  wkind;
        gcld_pkg::t_phase phase;
        logic        neg;
        logic [31:0] mag;
        int          fdig;
        int          code;
        int          motion, stop_sel, plane;
        logic        motion_seen, rel;
        logic [31:0] scal [4];
        logic [31:0] axv [9];
        logic [8:0]  axp;
        logic [3:0]  err_num;
        logic        err_on, empty;
        t_block_item pending_items [$];
        int          fails;

        function new();
            dwell_dflt = gcld_pkg::DWELL_RESET;
            wkind = gcld_pkg::KW_N; phase = gcld_pkg::PH_IDLE;
            clear_num();
            motion = 0; stop_sel = 0; plane = 0; motion_seen = 0; rel = 0;
            foreach (scal[i]) scal[i] = '0;
            foreach (axv[i]) axv[i] = '0;
            axp = '0; err_num = '0; err_on = 0; empty = 1; fails = 0;
        endfunction

        function void clear_num();
            neg = 0; mag = '0; fdig = 0; code = 0;
        endfunction

        function bit dig(byte unsigned c);
            return c >= "0" && c <= "9";
        endfunction

        function bit numc(byte unsigned c);
            return dig(c) || c == "+" || c == "-" || c == "." || c == "E" || c == "e";
        endfunction

        function void sat_store(longint unsigned m);
            mag = (m > 64'h8000_0000) ? 32'h8000_0000 : m[31:0];
        endfunction

        // integer digits are scaled to thousandths as they arrive
        function void int_byte(byte unsigned c);
            if (dig(c)) sat_store(longint'(mag) * 10 + longint'(c - "0") * 1000);
            else if (c == ".") phase = gcld_pkg::PH_FRAC;
            else phase = gcld_pkg::PH_SKIP;
        endfunction

        function void frac_byte(int d);
            int w;
            if (fdig < 3) begin
                w = (fdig == 0) ? 100 : (fdig == 1) ? 10 : 1;
                sat_store(longint'(mag) + longint'(d * w));
                fdig++;
            end
        endfunction

        function logic [31:0] fixed_val();
            if (neg) return 32'd0 - mag;
            return (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
        endfunction

        function void raise_err(logic [3:0] e);
            err_num = e; err_on = 1;
        endfunction

        function logic [3:0] missing_num_err();
            logic [3:0] tbl [16] = '{0, 1, 2, 3, 0, 7, 8, 4, 4, 4, 5, 5, 5, 6, 6, 6};
            return tbl[wkind];
        endfunction

        function void close_word();
            phase = gcld_pkg::PH_IDLE;
            if (wkind == gcld_pkg::KW_G) begin
                if (code <= 4) begin
                    if (motion_seen) begin
                        raise_err(gcld_pkg::ERR_G);
                        return;
                    end
                    motion = code + 1; motion_seen = 1;
                    if (code == 4) begin
                        wkind = gcld_pkg::KW_DWELL; clear_num(); phase = gcld_pkg::PH_DWELL;
                    end
                end else if (code >= 17 && code <= 19) plane = code - 17;
                else if (code == 90) rel = 0;
                else if (code == 91) rel = 1;
            end else if (wkind == gcld_pkg::KW_M) begin
                if (code == 0) stop_sel = 1;
                else if (code == 1) stop_sel = 2;
                else if (code == 30) stop_sel = 3;
                else raise_err(gcld_pkg::ERR_M);
            end else if (wkind >= gcld_pkg::KW_AXIS) begin
                axv[(wkind - gcld_pkg::KW_AXIS) % 9] = fixed_val();
            end else if (wkind >= gcld_pkg::KW_SCALAR) begin
                scal[(wkind - gcld_pkg::KW_SCALAR) & 3] = fixed_val();
            end
        endfunction

        function void push_item(logic [4:0] k, logic [31:0] v, logic p);
            t_block_item it;
            it.kind = k; it.value = v; it.present = p; it.last = 0;
            pending_items.push_back(it);
        endfunction

        function void emit_block();
            if (err_on) push_item(gcld_pkg::KIND_ERROR, 32'(err_num), 1);
            else begin
                push_item(gcld_pkg::KIND_MOTION, 32'(motion), 1);
                push_item(gcld_pkg::KIND_PLANE, 32'(plane), 1);
                push_item(gcld_pkg::KIND_REL, 32'(rel), 1);
                push_item(gcld_pkg::KIND_STOP, 32'(stop_sel), 1);
                for (int i = 0; i < 4; i++)
                    push_item(gcld_pkg::KIND_SCALAR + 5'(i), scal[i], 1);
                for (int i = 0; i < 9; i++)
                    push_item(gcld_pkg::KIND_AXIS + 5'(i), axv[i], axp[i]);
            end
            pending_items[$].last = 1;
            motion_seen = 0; axp = '0; stop_sel = 0; empty = 1;
        endfunction

        function void open_word(byte unsigned c);
            byte unsigned u;
            string axes;
            int k;
            axes = "XYZUVWIJK";
            u = (c >= "a" && c <= "z") ? c - 32 : c;
            k = -1;
            case (u)
                "N": k = gcld_pkg::KW_N;
                "G": k = gcld_pkg::KW_G;
                "M": k = gcld_pkg::KW_M;
                "F": k = gcld_pkg::KW_SCALAR;
                "R": k = gcld_pkg::KW_RADIUS;
                "A": k = gcld_pkg::KW_ANGLE;
                default: begin
                    for (int i = 0; i < 9; i++)
                        if (u == axes[i]) begin
                            k = gcld_pkg::KW_AXIS + i; axp[i] = 1;
                        end
                end
            endcase
            if (k < 0) return;
            wkind = 4'(k);
            clear_num();
            phase = gcld_pkg::PH_WAIT;
        endfunction

        // returns 1 when the byte has to be handled again
        function bit handle(byte unsigned c);
            bit cw;
            cw = wkind <= gcld_pkg::KW_M;
            case (phase)
                gcld_pkg::PH_IDLE: begin
                    if (c == 10 || c == 0) begin
                        if (!(c == 0 && empty)) emit_block();
                    end else open_word(c);
                    return 0;
                end
                gcld_pkg::PH_WAIT: begin
                    if (c == " ") return 0;
                    if (cw ? dig(c) : numc(c)) begin
                        phase = gcld_pkg::PH_INT;
                        if (cw) code = c - "0";
                        else if (c == "-") neg = 1;
                        else if (c != "+") int_byte(c);
                        return 0;
                    end
                    raise_err(missing_num_err());
                    phase = gcld_pkg::PH_IDLE;
                    return 1;
                end
                gcld_pkg::PH_INT: begin
                    if (cw) begin
                        if (dig(c)) begin
                            code = code * 10 + (c - "0");
                            if (code > 255) code = 255;
                            return 0;
                        end
                        close_word();
                        return 1;
                    end
                    if (numc(c)) begin
                        int_byte(c);
                        return 0;
                    end
                    close_word();
                    return 1;
                end
                gcld_pkg::PH_FRAC: begin
                    if (dig(c)) begin
                        frac_byte(c - "0");
                        return 0;
                    end
                    if (numc(c)) begin
                        phase = gcld_pkg::PH_SKIP;
                        return 0;
                    end
                    close_word();
                    return 1;
                end
                gcld_pkg::PH_SKIP: begin
                    if (numc(c)) return 0;
                    close_word();
                    return 1;
                end
                gcld_pkg::PH_DWELL: begin
                    if (c == " ") return 0;
                    if (dig(c)) begin
                        phase = gcld_pkg::PH_INT;
                        int_byte(c);
                        return 0;
                    end
                    scal[1] = 32'(dwell_dflt);
                    phase = gcld_pkg::PH_IDLE;
                    return 1;
                end
                default: begin
                    phase = gcld_pkg::PH_IDLE;
                    return 1;
                end
            endcase
        endfunction

        function void note_byte(byte unsigned c);
            if (c != 10 && c != 0) empty = 0;
            for (int p = 0; p < 4; p++)
                if (!handle(c)) break;
        endfunction

        function void check_item(logic [4:0] k, logic [31:0] v, logic p, logic l);
            t_block_item e;
            if (pending_items.size() == 0) begin
                $display("%0t: unexpected item kind=%0d value=%0d", $time, k, $signed(v));
                fails++;
                return;
            end
            e = pending_items.pop_front();
            if (k !== e.kind || v !== e.value || p !== e.present || l !== e.last) begin
                $display("%0t: item mismatch exp kind=%0d value=%0d present=%0b last=%0b",
                         $time, e.kind, $signed(e.value), e.present, e.last);
                $display("%0t:               act kind=%0d value=%0d present=%0b last=%0b",
                         $time, k, $signed(v), p, l);
                fails++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_ch;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [30:0]        i_dwell_default;
    logic               o_valid;
    logic               i_stall;
    logic [4:0]         o_item_kind;
    logic signed [31:0] o_item_value;
    logic               o_item_present;
    logic               o_last_item;

    gcode_line_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_dwell_default(i_dwell_default),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_item_kind    (o_item_kind),
        .o_item_value   (o_item_value),
        .o_item_present (o_item_present),
        .o_last_item    (o_last_item)
    );

    t_block_tracker     tracker;
    byte unsigned       text_q [$];   // bytes waiting to be sent
    int                 burst_left;
    bit                 gappy;        // sender inserts gaps between bursts
    int                 stall_level;  // 0: receiver never stalls
    int                 stall_run;
    int                 cycles;

    localparam int CYCLE_LIMIT = 400000;

    initial i_clk = 0;
    always #4 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern: runs of a random stall level, level 0 = no stalls
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_level = $urandom_range(0, 3);
            stall_run = $urandom_range(5, 60);
        end
        stall_run--;
        i_stall = (stall_level != 0) && ($urandom_range(0, 3) < stall_level);
    end

    // result side: compare every accepted item with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_item(o_item_kind, o_item_value, o_item_present, o_last_item);
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // send every queued byte; sender works in bursts, with random gaps between them when gappy is set
    task automatic flush_text();
        byte unsigned c;
        while (text_q.size() > 0) begin
            c = text_q.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                if (gappy) begin
                    i_valid = 0;
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end
            end
            i_valid = 1;
            i_ch = c;
            do @(posedge i_clk); while (o_stall);
            tracker.note_byte(c);
            burst_left--;
            @(negedge i_clk);
        end
        i_valid = 0;
    endtask

    // wait for the block to go idle, then load a new dwell default
    task automatic load_dwell(input logic [30:0] v);
        while (tracker.pending_items.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        i_cfg_valid = 1;
        i_dwell_default = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.dwell_dflt = v;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    function automatic string rand_number();
        string s;
        int r;
        s = "";
        r = $urandom_range(0, 3);
        if (r == 1) s = "-";
        else if (r == 2) s = "+";
        if ($urandom_range(0, 15) == 0) s = {s, $sformatf("%0d%0d", $urandom, $urandom)};
        else s = {s, $sformatf("%0d", $urandom_range(0, 9999))};
        if ($urandom_range(0, 1)) s = {s, ".", $sformatf("%0d", $urandom_range(0, 99999))};
        if ($urandom_range(0, 9) == 0) s = {s, ($urandom_range(0, 1) ? "e" : "E"),
                                             $sformatf("%0d", $urandom_range(0, 20))};
        return s;
    endfunction

    function automatic string case_mix(input byte unsigned l);
        string s;
        s = " ";
        s[0] = $urandom_range(0, 1) ? l + 32 : l;
        return s;
    endfunction

    // a well-formed line: at most one motion, known stop codes, numbers everywhere
    task automatic add_good_line();
        string axes, w;
        int    n, r;
        bit    moved;
        int    plain_g [6];
        int    stops [3];
        axes = "XYZUVWIJK";
        plain_g = '{17, 18, 19, 90, 91, 0};
        stops = '{0, 1, 30};
        moved = 0;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            case (r)
                0: w = {case_mix("N"), $sformatf("%0d", $urandom_range(0, 999))};
                1: begin
                    plain_g[5] = $urandom_range(5, 400);
                    w = {case_mix("G"), $sformatf("%0d", plain_g[$urandom_range(0, 5)])};
                end
                2: begin
                    if (moved) w = {case_mix("F"), rand_number()};
                    else begin
                        moved = 1;
                        r = $urandom_range(0, 4);
                        w = {case_mix("G"), $sformatf("%0d", r)};
                        if (r == 4 && $urandom_range(0, 1))
                            w = {w, " ", $sformatf("%0d.%0d", $urandom_range(0, 99),
                                                   $urandom_range(0, 999))};
                    end
                end
                3: w = {case_mix("M"), $sformatf("%0d", stops[$urandom_range(0, 2)])};
                4: w = {case_mix("F"), rand_number()};
                5: w = {case_mix("R"), rand_number()};
                6: w = {case_mix("A"), rand_number()};
                default: w = {case_mix(axes[$urandom_range(0, 8)]), rand_number()};
            endcase
            add_text(w);
            repeat ($urandom_range(0, 2)) add_text(" ");
        end
        text_q.push_back($urandom_range(0, 7) == 0 ? 8'd0 : 8'd10);
    endtask

    initial begin
        tracker = new();
        i_rst_n = 0;
        i_valid = 0;
        i_ch = '0;
        i_cfg_valid = 0;
        i_dwell_default = '0;
        i_stall = 0;
        stall_run = 0;
        stall_level = 0;
        burst_left = 0;
        gappy = 0;
        cycles = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: reset dwell, empty-line NUL, all words, both cases, saturation
        text_q.push_back(8'd0);
        add_text("G4\n");
        add_text("G1 X1.5 Y-2.25 Z+3 f100.1239\n");
        add_text("g0 x10e5 y.5 z-.0001 u7 v-8 w9.999\n");
        add_text("G2 I1 J2 K3 R5 A-90 M0 N12\n");
        add_text("G3G18 M1 X99999999999 Y-99999999999 Z2147483.6475\n");
        add_text("G19 G91 M30 G4 2.5 X3-4.5.6\n");
        add_text("G17 G90 G0999 Q5 $#\n");
        text_q.push_back(8'd0);
        flush_text();
        load_dwell(31'd0);
        add_text("G4 X1\n");
        flush_text();
        load_dwell(31'h7FFF_FFFF);
        add_text("G4\n");
        add_text("G4 ");
        text_q.push_back(8'd0);
        flush_text();

        // random well-formed lines, several dwell settings and idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            gappy = (ph != 1);
            load_dwell(ph == 3 ? 31'd1 : 31'($urandom));
            while (text_q.size() < 20) add_good_line();
            add_text("G4\n");
            flush_text();
        end

        // errors latch until reset, so they come last
        gappy = 1;
        add_text("G1 G2 X1\n");
        add_text("M5\n");
        add_text("X\nG\nN\nF\nU\nI\nR\nA\nM\n");
        flush_text();
        for (int i = 0; i < 40; i++) text_q.push_back($urandom_range(0, 255));
        for (int i = 0; i < 8; i++) text_q.push_back(i[0] ? 8'hAA : 8'h55);
        for (int i = 0; i < 3; i++) add_good_line();
        text_q.push_back(8'd10);
        flush_text();

        while (tracker.pending_items.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (tracker.fails == 0 && tracker.pending_items.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/gcld_pkg.sv
rtl/core/gcld_ram.sv
rtl/core/gcode_line_decoder.sv
test/gcode_line_decoder_test.sv
